### rtl/sidtoa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sidtoa_pkg
// Shared constants and elaboration-time helpers for the signed integer to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package sidtoa_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;

    // Number of magnitude bits handled by one double-dabble stage.
    localparam int DABBLE_BITS = 8;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // log10(2) scaled by LOG_SCALE, used to size the digit store.
    localparam int LOG2_OF_TEN_NUM = 30103;
    localparam int LOG_SCALE       = 100000;

    // Decimal digits needed for a magnitude of up to 2**(width-1).
    function automatic int num_digits(input int width);
        return ((width - 1) * LOG2_OF_TEN_NUM) / LOG_SCALE + 1;
    endfunction

    // Double-dabble stages needed to cover a magnitude of width bits.
    function automatic int num_stages(input int width);
        return (width + DABBLE_BITS - 1) / DABBLE_BITS;
    endfunction

endpackage
`default_nettype wire

### rtl/sidtoa_negate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sidtoa_negate
// First pipeline stage: splits the signed input into a sign flag and an
// unsigned magnitude, zero-padded to the double-dabble width.
// ----------------------------------------------------------------------------
module sidtoa_negate
    import sidtoa_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
    parameter int MAG_WIDTH   = DABBLE_BITS * num_stages(DEFAULT_VALUE_WIDTH)
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] in_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_negative,
    output logic [MAG_WIDTH-1:0]               out_mag
);

    logic                   valid_reg;
    logic                   negative_reg;
    logic [MAG_WIDTH-1:0]   mag_reg;
    logic [VALUE_WIDTH-1:0] raw;
    logic [MAG_WIDTH-1:0]   mag_next;

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign out_negative = negative_reg;
    assign out_mag      = mag_reg;

    // The most negative value negates to 2**(VALUE_WIDTH-1), which still fits
    // as an unsigned number of VALUE_WIDTH bits.
    always_comb
    begin
        raw      = $unsigned(in_value);
        mag_next = '0;
        mag_next[VALUE_WIDTH-1:0] = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            negative_reg <= in_value[VALUE_WIDTH-1];
            mag_reg      <= mag_next;
        end
    end

endmodule
`default_nettype wire

### rtl/sidtoa_dabble_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sidtoa_dabble_stage
// One registered double-dabble stage: shifts DABBLE_BITS magnitude bits,
// most significant first, into the packed BCD digits.
// ----------------------------------------------------------------------------
module sidtoa_dabble_stage
    import sidtoa_pkg::*;
#(
    parameter int NUM_DIGITS = num_digits(DEFAULT_VALUE_WIDTH),
    parameter int MAG_WIDTH  = DABBLE_BITS * num_stages(DEFAULT_VALUE_WIDTH)
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      in_negative,
    input  wire logic [4*NUM_DIGITS-1:0]   in_bcd,
    input  wire logic [MAG_WIDTH-1:0]      in_bin,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           out_negative,
    output logic [4*NUM_DIGITS-1:0]        out_bcd,
    output logic [MAG_WIDTH-1:0]           out_bin
);

    localparam int BCD_WIDTH = 4 * NUM_DIGITS;

    logic                 valid_reg;
    logic                 negative_reg;
    logic [BCD_WIDTH-1:0] bcd_reg;
    logic [MAG_WIDTH-1:0] bin_reg;
    logic [BCD_WIDTH-1:0] bcd_next;
    logic [MAG_WIDTH-1:0] bin_next;

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign out_negative = negative_reg;
    assign out_bcd      = bcd_reg;
    assign out_bin      = bin_reg;

    // Each step adds three to every digit of five or more, then shifts the
    // whole BCD and binary word left by one.
    always_comb
    begin
        bcd_next = in_bcd;
        bin_next = in_bin;
        for (int s = 0; s < DABBLE_BITS; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (bcd_next[d*4 +: 4] >= 4'd5)
                begin
                    bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
                end
            end
            {bcd_next, bin_next} = {bcd_next[BCD_WIDTH-2:0], bin_next, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            negative_reg <= in_negative;
            bcd_reg      <= bcd_next;
            bin_reg      <= bin_next;
        end
    end

endmodule
`default_nettype wire

### rtl/sidtoa_count.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sidtoa_count
// Finds the most significant nonzero digit, so that the output stage can
// skip leading zeros. A zero value keeps one digit.
// ----------------------------------------------------------------------------
module sidtoa_count
    import sidtoa_pkg::*;
#(
    parameter int NUM_DIGITS = num_digits(DEFAULT_VALUE_WIDTH),
    parameter int IDX_WIDTH  = $clog2(num_digits(DEFAULT_VALUE_WIDTH))
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    in_negative,
    input  wire logic [4*NUM_DIGITS-1:0] in_bcd,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         out_negative,
    output logic [4*NUM_DIGITS-1:0]      out_bcd,
    output logic [IDX_WIDTH-1:0]         out_top
);

    logic                      valid_reg;
    logic                      negative_reg;
    logic [4*NUM_DIGITS-1:0]   bcd_reg;
    logic [IDX_WIDTH-1:0]      top_reg;
    logic [IDX_WIDTH-1:0]      top_next;

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign out_negative = negative_reg;
    assign out_bcd      = bcd_reg;
    assign out_top      = top_reg;

    always_comb
    begin
        top_next = '0;
        for (int d = 1; d < NUM_DIGITS; d++)
        begin
            if (in_bcd[d*4 +: 4] != 4'd0)
            begin
                top_next = IDX_WIDTH'(d);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            negative_reg <= in_negative;
            bcd_reg      <= in_bcd;
            top_reg      <= top_next;
        end
    end

endmodule
`default_nettype wire

### rtl/sidtoa_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sidtoa_emit
// Output register and character sequencer: sends the optional minus sign,
// then the digits from the most significant nonzero one down to digit 0.
// ----------------------------------------------------------------------------
module sidtoa_emit
    import sidtoa_pkg::*;
#(
    parameter int NUM_DIGITS = num_digits(DEFAULT_VALUE_WIDTH),
    parameter int IDX_WIDTH  = $clog2(num_digits(DEFAULT_VALUE_WIDTH))
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    in_negative,
    input  wire logic [4*NUM_DIGITS-1:0] in_bcd,
    input  wire logic [IDX_WIDTH-1:0]    in_top,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [7:0]                   character,
    output logic                         last
);

    logic                        busy_reg;
    logic                        busy_next;
    logic                        sign_reg;
    logic                        sign_next;
    logic [IDX_WIDTH-1:0]        idx_reg;
    logic [IDX_WIDTH-1:0]        idx_next;
    logic [NUM_DIGITS-1:0][3:0]  digits_reg;
    logic                        load;
    logic                        fire;

    assign last      = !sign_reg && (idx_reg == '0);
    assign out_valid = busy_reg;
    assign character = sign_reg ? ASCII_MINUS : (ASCII_ZERO + {4'd0, digits_reg[idx_reg]});

    // A new number loads in the same cycle that the final character of the
    // previous one is taken, so characters leave back to back.
    assign in_ready = !busy_reg || (out_ready && last);
    assign load     = in_valid && in_ready;
    assign fire     = busy_reg && out_ready;

    always_comb
    begin
        busy_next = busy_reg;
        sign_next = sign_reg;
        idx_next  = idx_reg;
        if (fire)
        begin
            if (sign_reg)
            begin
                sign_next = 1'b0;
            end
            else if (idx_reg != '0)
            begin
                idx_next = idx_reg - 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            sign_next = in_negative;
            idx_next  = in_top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sign_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            sign_reg <= sign_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digits_reg <= in_bcd;
        end
    end

endmodule
`default_nettype wire

### rtl/signed_int_to_decimal_ascii_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed integer to its decimal ASCII text, one character per
// transaction, most significant first, with last on the final character.
// ----------------------------------------------------------------------------
//   Channel | Handshake          | Payload
//   --------+--------------------+------------------------------------------
//   input   | in_valid/in_ready  | value [VALUE_WIDTH-1:0], signed
//   output  | out_valid/out_ready| character [7:0], last
//
// A number occupies the output sequencer for one transaction per character:
// 1 to 11 characters at 32 bits (digits plus an optional sign). Characters of
// successive numbers leave back to back. The input passes through one negate
// stage, one double-dabble stage per 8 magnitude bits, one digit-count stage
// and the output register before its first character is valid. Reset clears
// only valid and sequencer state; a stall on the output holds every stage
// that holds a number in place.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top
    import sidtoa_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [7:0]                         character,
    output logic                               last
);

    localparam int NUM_DIGITS = num_digits(VALUE_WIDTH);
    localparam int NUM_STAGES = num_stages(VALUE_WIDTH);
    localparam int MAG_WIDTH  = DABBLE_BITS * NUM_STAGES;
    localparam int BCD_WIDTH  = 4 * NUM_DIGITS;
    localparam int IDX_WIDTH  = $clog2(NUM_DIGITS);

    logic                 stg_valid    [NUM_STAGES+1];
    logic                 stg_ready    [NUM_STAGES+1];
    logic                 stg_negative [NUM_STAGES+1];
    logic [BCD_WIDTH-1:0] stg_bcd      [NUM_STAGES+1];
    logic [MAG_WIDTH-1:0] stg_bin      [NUM_STAGES];

    logic                 cnt_valid;
    logic                 cnt_ready;
    logic                 cnt_negative;
    logic [BCD_WIDTH-1:0] cnt_bcd;
    logic [IDX_WIDTH-1:0] cnt_top;

    assign stg_bcd[0] = '0;

    sidtoa_negate #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAG_WIDTH   (MAG_WIDTH)
    ) u_negate (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_value     (value),
        .out_valid    (stg_valid[0]),
        .out_ready    (stg_ready[0]),
        .out_negative (stg_negative[0]),
        .out_mag      (stg_bin[0])
    );

    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_dabble
        if (k < NUM_STAGES - 1)
        begin : g_mid
            sidtoa_dabble_stage #(
                .NUM_DIGITS (NUM_DIGITS),
                .MAG_WIDTH  (MAG_WIDTH)
            ) u_stage (
                .clk          (clk),
                .rst_n        (rst_n),
                .in_valid     (stg_valid[k]),
                .in_ready     (stg_ready[k]),
                .in_negative  (stg_negative[k]),
                .in_bcd       (stg_bcd[k]),
                .in_bin       (stg_bin[k]),
                .out_valid    (stg_valid[k+1]),
                .out_ready    (stg_ready[k+1]),
                .out_negative (stg_negative[k+1]),
                .out_bcd      (stg_bcd[k+1]),
                .out_bin      (stg_bin[k+1])
            );
        end
        else
        begin : g_final
            // All magnitude bits are consumed here; the shifted-out word is
            // not needed further down.
            sidtoa_dabble_stage #(
                .NUM_DIGITS (NUM_DIGITS),
                .MAG_WIDTH  (MAG_WIDTH)
            ) u_stage (
                .clk          (clk),
                .rst_n        (rst_n),
                .in_valid     (stg_valid[k]),
                .in_ready     (stg_ready[k]),
                .in_negative  (stg_negative[k]),
                .in_bcd       (stg_bcd[k]),
                .in_bin       (stg_bin[k]),
                .out_valid    (stg_valid[k+1]),
                .out_ready    (stg_ready[k+1]),
                .out_negative (stg_negative[k+1]),
                .out_bcd      (stg_bcd[k+1]),
                .out_bin      ()
            );
        end
    end

    sidtoa_count #(
        .NUM_DIGITS (NUM_DIGITS),
        .IDX_WIDTH  (IDX_WIDTH)
    ) u_count (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (stg_valid[NUM_STAGES]),
        .in_ready     (stg_ready[NUM_STAGES]),
        .in_negative  (stg_negative[NUM_STAGES]),
        .in_bcd       (stg_bcd[NUM_STAGES]),
        .out_valid    (cnt_valid),
        .out_ready    (cnt_ready),
        .out_negative (cnt_negative),
        .out_bcd      (cnt_bcd),
        .out_top      (cnt_top)
    );

    sidtoa_emit #(
        .NUM_DIGITS (NUM_DIGITS),
        .IDX_WIDTH  (IDX_WIDTH)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cnt_valid),
        .in_ready    (cnt_ready),
        .in_negative (cnt_negative),
        .in_bcd      (cnt_bcd),
        .in_top      (cnt_top),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .character   (character),
        .last        (last)
    );

    // Every character sent is a minus sign or a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character == ASCII_MINUS) ||
                      ((character >= ASCII_ZERO) && (character <= ASCII_ZERO + 8'd9)))
        else $error("character outside sign and digit codes");

    // A minus sign is never the final character of a number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (character == ASCII_MINUS)) |-> !last)
        else $error("minus sign flagged as last");

    // A minus sign only opens a number: it never follows a non-final character.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(out_valid && out_ready && !last) && out_valid) |-> (character != ASCII_MINUS))
        else $error("minus sign inside a number");

    // The first digit after a sign is never a leading zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(out_valid && out_ready && (character == ASCII_MINUS)) && out_valid)
            |-> (character != ASCII_ZERO))
        else $error("leading zero after minus sign");

endmodule
`default_nettype wire
